### src/vlid_pkg.sv
package vlid_pkg;

  // opcode bytes of the instruction set
  localparam logic [7:0] OP_MOV_RR    = 8'h1A;
  localparam logic [7:0] OP_MOV_AR    = 8'h1B;
  localparam logic [7:0] OP_SUB_RRR   = 8'h0C;
  localparam logic [7:0] OP_SUB_RRA   = 8'h0D;
  localparam logic [7:0] OP_MUL_RRR   = 8'h21;
  localparam logic [7:0] OP_MUL_RRA   = 8'h23;
  localparam logic [7:0] OP_CMP_RR    = 8'h80;
  localparam logic [7:0] OP_MOV_LIT   = 8'h1C;

  // upper nibble of the second byte that selects the literal width
  localparam logic [3:0] LIT_SEL_8    = 4'h0;
  localparam logic [3:0] LIT_SEL_16   = 4'h1;

  // result kinds
  localparam logic [3:0] KIND_UNKNOWN   = 4'd0;
  localparam logic [3:0] KIND_MOV_RR    = 4'd1;
  localparam logic [3:0] KIND_MOV_AR    = 4'd2;
  localparam logic [3:0] KIND_SUB_RRR   = 4'd3;
  localparam logic [3:0] KIND_SUB_RRA   = 4'd4;
  localparam logic [3:0] KIND_MUL_RRR   = 4'd5;
  localparam logic [3:0] KIND_MUL_RRA   = 4'd6;
  localparam logic [3:0] KIND_CMP       = 4'd7;
  localparam logic [3:0] KIND_LIT8      = 4'd8;
  localparam logic [3:0] KIND_LIT16     = 4'd9;
  localparam logic [3:0] KIND_MALFORMED = 4'd10;
  localparam logic [3:0] KIND_TRUNCATED = 4'd11;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_stream;
  } code_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  first_byte;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [3:0]  reg_c;
    logic [15:0] literal;
    logic [31:0] virtual_address;
    logic [2:0]  length;
  } result_item_t;

  // bytes held of the instruction in progress
  typedef struct packed {
    logic [2:0]  position;
    logic [7:0]  opcode;
    logic [7:0]  second;
    logic [31:0] shift;
  } decode_state_t;

  // opcode starts a known instruction form
  function automatic logic opcode_known(input logic [7:0] op);
    logic known;
    known = 1'b0;
    case (op) inside
      OP_MOV_RR, OP_MOV_AR, OP_SUB_RRR, OP_SUB_RRA,
      OP_MUL_RRR, OP_MUL_RRA, OP_CMP_RR, OP_MOV_LIT: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

  // total length once the second byte is in
  function automatic logic [2:0] form_length(input logic [7:0] op, input logic [7:0] second);
    logic [2:0] len;
    len = 3'd2;
    case (op) inside
      OP_MOV_RR, OP_CMP_RR:               len = 3'd2;
      OP_SUB_RRR, OP_MUL_RRR:             len = 3'd3;
      OP_MOV_AR, OP_SUB_RRA, OP_MUL_RRA:  len = 3'd6;
      OP_MOV_LIT: begin
        if (second[7:4] == LIT_SEL_8) begin
          len = 3'd3;
        end else if (second[7:4] == LIT_SEL_16) begin
          len = 3'd4;
        end else begin
          len = 3'd2;
        end
      end
      default: len = 3'd2;
    endcase
    return len;
  endfunction

endpackage

### src/vlid_decode.sv
module vlid_decode (
  input  vlid_pkg::decode_state_t state,
  input  vlid_pkg::code_item_t    item,
  output vlid_pkg::decode_state_t state_next,
  output logic                    emit,
  output vlid_pkg::result_item_t  result
);

  logic [2:0] target;

  // fields of a completed instruction
  function automatic vlid_pkg::result_item_t complete(input vlid_pkg::decode_state_t s,
                                                      input logic [2:0] len);
    vlid_pkg::result_item_t r;
    r = '0;
    r.first_byte = s.opcode;
    r.length = len;
    unique case (s.opcode)
      vlid_pkg::OP_MOV_RR: begin
        r.kind = vlid_pkg::KIND_MOV_RR;
        r.reg_a = s.second[7:4];
        r.reg_b = s.second[3:0];
      end
      vlid_pkg::OP_CMP_RR: begin
        r.kind = vlid_pkg::KIND_CMP;
        r.reg_a = s.second[7:4];
        r.reg_b = s.second[3:0];
      end
      vlid_pkg::OP_MOV_AR: begin
        r.kind = vlid_pkg::KIND_MOV_AR;
        r.reg_a = s.second[3:0];
        r.virtual_address = s.shift;
      end
      vlid_pkg::OP_SUB_RRR: begin
        r.kind = vlid_pkg::KIND_SUB_RRR;
        r.reg_a = s.second[3:0];
        r.reg_b = s.shift[7:4];
        r.reg_c = s.shift[3:0];
      end
      vlid_pkg::OP_MUL_RRR: begin
        r.kind = vlid_pkg::KIND_MUL_RRR;
        r.reg_a = s.second[3:0];
        r.reg_b = s.shift[7:4];
        r.reg_c = s.shift[3:0];
      end
      vlid_pkg::OP_SUB_RRA: begin
        r.kind = vlid_pkg::KIND_SUB_RRA;
        r.reg_a = s.second[7:4];
        r.reg_b = s.second[3:0];
        r.virtual_address = s.shift;
      end
      vlid_pkg::OP_MUL_RRA: begin
        r.kind = vlid_pkg::KIND_MUL_RRA;
        r.reg_a = s.second[7:4];
        r.reg_b = s.second[3:0];
        r.virtual_address = s.shift;
      end
      default: begin
        // literal move: width picked by the upper nibble of the second byte
        if (s.second[7:4] == vlid_pkg::LIT_SEL_8) begin
          r.kind = vlid_pkg::KIND_LIT8;
          r.reg_a = s.second[3:0];
          r.literal = {8'h00, s.shift[7:0]};
        end else if (s.second[7:4] == vlid_pkg::LIT_SEL_16) begin
          r.kind = vlid_pkg::KIND_LIT16;
          r.reg_a = s.second[3:0];
          r.literal = s.shift[15:0];
        end else begin
          r.kind = vlid_pkg::KIND_MALFORMED;
        end
      end
    endcase
    return r;
  endfunction

  // one byte step of the decoder
  always_comb begin
    state_next = state;
    emit = 1'b0;
    result = '0;
    target = 3'd2;
    if (state.position == 3'd0) begin
      if (!vlid_pkg::opcode_known(item.code_byte)) begin
        // unknown opcode: one-byte result
        emit = 1'b1;
        result.kind = vlid_pkg::KIND_UNKNOWN;
        result.first_byte = item.code_byte;
        result.length = 3'd1;
      end else begin
        state_next = '0;
        state_next.opcode = item.code_byte;
        state_next.position = 3'd1;
        if (item.end_of_stream) begin
          emit = 1'b1;
          result.kind = vlid_pkg::KIND_TRUNCATED;
          result.first_byte = item.code_byte;
          result.length = 3'd1;
          state_next = '0;
        end
      end
    end else begin
      // collect the byte
      if (state.position == 3'd1) begin
        state_next.second = item.code_byte;
        state_next.position = 3'd2;
      end else begin
        state_next.shift = {state.shift[23:0], item.code_byte};
        state_next.position = 3'(state.position + 3'd1);
      end
      target = vlid_pkg::form_length(state.opcode, state_next.second);
      if (state_next.position >= target) begin
        emit = 1'b1;
        result = complete(state_next, target);
        state_next = '0;
      end else if (item.end_of_stream) begin
        emit = 1'b1;
        result.kind = vlid_pkg::KIND_TRUNCATED;
        result.first_byte = state.opcode;
        result.length = state_next.position;
        state_next = '0;
      end
    end
  end

endmodule

### src/variable_length_instruction_decoder_unit.sv
// Byte-serial decoder for a variable-length instruction set.
// Latency: a result appears in the cycle after the transfer of its final byte.
// Throughput: one byte per cycle while the result register is free or draining;
// the decode step between the held-byte state and the result register is a single pass of field extraction.
// Reset (rst, synchronous): waits for an opcode, no result pending.
module variable_length_instruction_decoder_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   code_valid,
  output logic                   code_ready,
  input  vlid_pkg::code_item_t   code,
  output logic                   result_valid,
  input  logic                   result_ready,
  output vlid_pkg::result_item_t result
);

  vlid_pkg::decode_state_t state;
  vlid_pkg::decode_state_t state_next;
  vlid_pkg::result_item_t  result_next;
  logic                    emit;
  logic                    code_xfer;

  // a byte moves in whenever the result register is free or draining
  assign code_ready = !result_valid || result_ready;
  assign code_xfer  = code_valid && code_ready;

  vlid_decode u_decode (
    .state      (state),
    .item       (code),
    .state_next (state_next),
    .emit       (emit),
    .result     (result_next)
  );

  // held bytes of the instruction in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (code_xfer) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (code_xfer && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (code_xfer && emit) begin
      result <= result_next;
    end
  end

endmodule
